@@ hw/rtl/thermal_safety_monitor_assert.svh @@
// Assertion macros shared by the thermal safety monitor RTL.
`ifndef THERMAL_SAFETY_MONITOR_ASSERT_SVH
`define THERMAL_SAFETY_MONITOR_ASSERT_SVH
`ifndef SYNTHESIS
// Plain property check, sampled on the rising clock edge, off during reset.
`define TSM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("thermal_safety_monitor: assertion failed");
// Same-cycle implication check.
`define TSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thermal_safety_monitor: implication failed");
// Next-cycle implication check.
`define TSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thermal_safety_monitor: next-cycle implication failed");
`else
`define TSM_ASSERT(label, clk, rst_n, prop)
`define TSM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/tsm_pkg.sv @@
// Shared types and constants of the thermal safety monitor.
package tsm_pkg;

    // Default widths of the temperature path and the second counters.
    localparam int DEFAULT_TEMP_BITS  = 14;
    localparam int DEFAULT_COUNT_BITS = 16;

    // Fixed field widths.
    localparam int MIN_RISE_BITS = 12;
    localparam int SECONDS_BITS  = 16;
    localparam int DUTY_BITS     = 10;
    localparam int DELTA_BITS    = 8;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CMP_BITS      = 32;

    // Duty above this value (tenths of a percent) counts as heating.
    localparam logic [DUTY_BITS-1:0] HEAT_THRESHOLD = 10'd500;

    // Register reset values.
    localparam int CEILING_RESET = 1120;
    localparam logic [MIN_RISE_BITS-1:0] MIN_RISE_RESET = 12'd8;
    localparam logic [SECONDS_BITS-1:0]  WINDOW_RESET   = 16'd20;
    localparam logic [SECONDS_BITS-1:0]  STALL_RESET    = 16'd5;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CEILING  = 2'd0,
        REG_MIN_RISE = 2'd1,
        REG_WINDOW   = 2'd2,
        REG_STALL    = 2'd3
    } cfg_reg_t;

    // Fault codes in priority order.
    typedef enum logic [2:0] {
        FAULT_OK       = 3'd0,
        FAULT_SENSOR   = 3'd1,
        FAULT_OVERTEMP = 3'd2,
        FAULT_STALL    = 3'd3,
        FAULT_RUNAWAY  = 3'd4
    } fault_code_t;

endpackage

@@ hw/rtl/tsm_eval.sv @@
// Fault evaluation with the stall counter and runaway window state.
module tsm_eval #(
    parameter int TEMP_BITS  = tsm_pkg::DEFAULT_TEMP_BITS,
    parameter int COUNT_BITS = tsm_pkg::DEFAULT_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                enable,
    input  logic signed [TEMP_BITS-1:0]         temp_quarter,
    input  logic                                sensor_ok,
    input  logic [tsm_pkg::DUTY_BITS-1:0]       duty_permille,
    input  logic                                fresh,
    input  logic [tsm_pkg::DELTA_BITS-1:0]      delta_seconds,
    input  logic signed [TEMP_BITS-1:0]         ceiling_temp,
    input  logic [tsm_pkg::MIN_RISE_BITS-1:0]   min_rise,
    input  logic [tsm_pkg::SECONDS_BITS-1:0]    window_seconds,
    input  logic [tsm_pkg::SECONDS_BITS-1:0]    stall_seconds,
    output tsm_pkg::fault_code_t                fault_code
);
    import tsm_pkg::*;

    // Rise arithmetic needs room for the exact difference and the unsigned limit.
    localparam int RISE_BITS = (TEMP_BITS + 2 > MIN_RISE_BITS + 2) ?
                               TEMP_BITS + 2 : MIN_RISE_BITS + 2;

    logic [COUNT_BITS-1:0]       since_fresh_reg, since_fresh_next;
    logic [COUNT_BITS-1:0]       window_elapsed_reg, window_elapsed_next;
    logic signed [TEMP_BITS-1:0] window_base_temp_reg, window_base_temp_next;

    logic [COUNT_BITS:0]         fresh_sum;
    logic [COUNT_BITS:0]         window_sum;
    logic [COUNT_BITS-1:0]       fresh_sat;
    logic [COUNT_BITS-1:0]       window_sat;
    logic                        stall_trip;
    logic                        window_done;
    logic                        heating;
    logic                        over_temp;
    logic signed [RISE_BITS-1:0] rise;
    logic signed [RISE_BITS-1:0] min_rise_ext;

    // Saturating second counters.
    assign fresh_sum  = {1'b0, since_fresh_reg} + (COUNT_BITS + 1)'(delta_seconds);
    assign window_sum = {1'b0, window_elapsed_reg} + (COUNT_BITS + 1)'(delta_seconds);
    assign fresh_sat  = fresh_sum[COUNT_BITS] ? '1 : fresh_sum[COUNT_BITS-1:0];
    assign window_sat = window_sum[COUNT_BITS] ? '1 : window_sum[COUNT_BITS-1:0];

    // Threshold compares; the second counts are zero extended to a common width.
    assign stall_trip  = CMP_BITS'(fresh_sat) >= CMP_BITS'(stall_seconds);
    assign window_done = CMP_BITS'(window_sat) >= CMP_BITS'(window_seconds);
    assign heating     = duty_permille > HEAT_THRESHOLD;
    assign over_temp   = temp_quarter >= ceiling_temp;

    // Exact signed rise over the window.
    assign rise         = RISE_BITS'(temp_quarter) - RISE_BITS'(window_base_temp_reg);
    assign min_rise_ext = $signed(RISE_BITS'(min_rise));

    // Priority checks; a check that trips leaves the later state alone.
    always_comb
    begin
        since_fresh_next      = since_fresh_reg;
        window_elapsed_next   = window_elapsed_reg;
        window_base_temp_next = window_base_temp_reg;
        fault_code            = FAULT_OK;
        priority if (!sensor_ok)
        begin
            fault_code = FAULT_SENSOR;
        end
        else if (over_temp)
        begin
            fault_code = FAULT_OVERTEMP;
        end
        else if (stall_trip)
        begin
            since_fresh_next = fresh_sat;
            fault_code       = FAULT_STALL;
        end
        else
        begin
            since_fresh_next = fresh ? '0 : fresh_sat;
            priority if (!heating)
            begin
                window_base_temp_next = temp_quarter;
                window_elapsed_next   = '0;
            end
            else if (window_elapsed_reg == '0)
            begin
                // First heating tick captures the baseline and starts the elapsed count.
                window_base_temp_next = temp_quarter;
                window_elapsed_next   = window_sat;
            end
            else if (window_done)
            begin
                window_base_temp_next = temp_quarter;
                window_elapsed_next   = '0;
                if (rise < min_rise_ext)
                begin
                    fault_code = FAULT_RUNAWAY;
                end
            end
            else
            begin
                window_elapsed_next = window_sat;
            end
        end
    end

    // State advances once per transaction that moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_fresh_reg      <= '0;
            window_elapsed_reg   <= '0;
            window_base_temp_reg <= '0;
        end
        else if (enable)
        begin
            since_fresh_reg      <= since_fresh_next;
            window_elapsed_reg   <= window_elapsed_next;
            window_base_temp_reg <= window_base_temp_next;
        end
    end

endmodule

@@ hw/rtl/thermal_safety_monitor.sv @@
// An accepted tick moves from the input register into the result register once that is free,
// and the fault code is offered from it. The two registers form a two-deep pipeline.
// Throughput: one tick per cycle while fault_stall does not hold back a full pipeline.
// The runaway and stall state updates as each tick moves into the result register.
// Reset (rst_n low, asynchronous) empties the pipeline, clears the state to zero
// and loads the configuration registers with their defaults.
`include "thermal_safety_monitor_assert.svh"

module thermal_safety_monitor #(
    parameter int TEMP_BITS  = tsm_pkg::DEFAULT_TEMP_BITS,
    parameter int COUNT_BITS = tsm_pkg::DEFAULT_COUNT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Tick channel.
    input  logic                                 tick_valid,
    output logic                                 tick_stall,
    input  logic signed [TEMP_BITS-1:0]          temp_quarter,
    input  logic                                 sensor_ok,
    input  logic [tsm_pkg::DUTY_BITS-1:0]        duty_permille,
    input  logic                                 fresh,
    input  logic [tsm_pkg::DELTA_BITS-1:0]       delta_seconds,
    // Fault channel.
    output logic                                 fault_valid,
    input  logic                                 fault_stall,
    output tsm_pkg::fault_code_t                 fault_code,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tsm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tsm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import tsm_pkg::*;

    // Configuration registers.
    logic signed [TEMP_BITS-1:0]   ceiling_temp_reg;
    logic [MIN_RISE_BITS-1:0]      min_rise_reg;
    logic [SECONDS_BITS-1:0]       window_seconds_reg;
    logic [SECONDS_BITS-1:0]       stall_seconds_reg;

    // Input register stage.
    logic                          s1_valid_reg, s1_valid_next;
    logic signed [TEMP_BITS-1:0]   temp_reg;
    logic                          ok_reg;
    logic [DUTY_BITS-1:0]          duty_reg;
    logic                          fresh_reg;
    logic [DELTA_BITS-1:0]         delta_reg;

    // Result register stage.
    logic                          fault_valid_reg, fault_valid_next;
    fault_code_t                   fault_code_reg;
    fault_code_t                   eval_code;

    logic                          tick_accept;
    logic                          advance;
    cfg_reg_t                      cfg_sel;

    // Pipeline handshake: the input stage moves on whenever the result register is free.
    assign advance     = s1_valid_reg && (!fault_valid_reg || !fault_stall);
    assign tick_stall  = s1_valid_reg && fault_valid_reg && fault_stall;
    assign tick_accept = tick_valid && !tick_stall;

    assign s1_valid_next    = tick_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign fault_valid_next = advance ? 1'b1 :
                              ((fault_valid_reg && !fault_stall) ? 1'b0 : fault_valid_reg);

    assign fault_valid = fault_valid_reg;
    assign fault_code  = fault_code_reg;
    assign cfg_ready   = 1'b1;
    assign cfg_sel     = cfg_reg_t'(cfg_index);

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            fault_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            fault_valid_reg <= fault_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            temp_reg  <= temp_quarter;
            ok_reg    <= sensor_ok;
            duty_reg  <= duty_permille;
            fresh_reg <= fresh;
            delta_reg <= delta_seconds;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fault_code_reg <= eval_code;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_temp_reg   <= TEMP_BITS'(CEILING_RESET);
            min_rise_reg       <= MIN_RISE_RESET;
            window_seconds_reg <= WINDOW_RESET;
            stall_seconds_reg  <= STALL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_sel)
                REG_CEILING:  ceiling_temp_reg   <= cfg_data[TEMP_BITS-1:0];
                REG_MIN_RISE: min_rise_reg       <= cfg_data[MIN_RISE_BITS-1:0];
                REG_WINDOW:   window_seconds_reg <= cfg_data[SECONDS_BITS-1:0];
                REG_STALL:    stall_seconds_reg  <= cfg_data[SECONDS_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Fault evaluation and monitor state.
    tsm_eval #(
        .TEMP_BITS  (TEMP_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_eval (
        .clk            (clk),
        .rst_n          (rst_n),
        .enable         (advance),
        .temp_quarter   (temp_reg),
        .sensor_ok      (ok_reg),
        .duty_permille  (duty_reg),
        .fresh          (fresh_reg),
        .delta_seconds  (delta_reg),
        .ceiling_temp   (ceiling_temp_reg),
        .min_rise       (min_rise_reg),
        .window_seconds (window_seconds_reg),
        .stall_seconds  (stall_seconds_reg),
        .fault_code     (eval_code)
    );

    // The input side only waits when both stages are full and the result is held.
    `TSM_ASSERT_IMPL(a_stall_needs_full, clk, rst_n, tick_stall, fault_valid && fault_stall)
    // An accepted tick is held in the input stage at the next cycle.
    `TSM_ASSERT_NEXT(a_accept_fills, clk, rst_n, tick_accept, s1_valid_reg)
    // A tick that leaves the input stage shows up as a result.
    `TSM_ASSERT_NEXT(a_advance_shows, clk, rst_n, advance, fault_valid)

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the thermal safety monitor: directed, register and random ticks.
`timescale 1ns / 100ps

module tb_top;
    import tsm_pkg::*;

    localparam int TEMP_W   = DEFAULT_TEMP_BITS;
    localparam int CNT_W    = DEFAULT_COUNT_BITS;
    localparam int TEMP_MAX = (1 << (TEMP_W - 1)) - 1;
    localparam int TEMP_MIN = -(1 << (TEMP_W - 1));

    // One tick as offered on the tick channel.
    typedef struct packed {
        logic [TEMP_W-1:0]     temp;
        logic                  ok;
        logic [DUTY_BITS-1:0]  duty;
        logic                  fresh;
        logic [DELTA_BITS-1:0] delta;
    } tick_t;

    // One predicted fault code, tagged with the tick that caused it.
    typedef struct packed {
        fault_code_t code;
        int          tick_no;
    } fault_expect_t;

    typedef enum int {
        EP_WELL,
        EP_BROKEN,
        EP_NOISE
    } episode_kind_t;

    logic                      clk;
    logic                      rst_n;
    logic                      tick_valid;
    logic                      tick_stall;
    logic signed [TEMP_W-1:0]  temp_quarter;
    logic                      sensor_ok;
    logic [DUTY_BITS-1:0]      duty_permille;
    logic                      fresh;
    logic [DELTA_BITS-1:0]     delta_seconds;
    logic                      fault_valid;
    logic                      fault_stall = 1'b0;
    fault_code_t               fault_code;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // Shadow copy of the configuration registers.
    logic signed [TEMP_W-1:0]  ceil_q;
    logic [MIN_RISE_BITS-1:0]  rise_min_q;
    logic [SECONDS_BITS-1:0]   window_len_q;
    logic [SECONDS_BITS-1:0]   stall_len_q;

    // Shadow copy of the monitor state.
    logic [CNT_W-1:0]          since_fresh_q;
    logic [CNT_W-1:0]          win_elapsed_q;
    logic signed [TEMP_W-1:0]  win_base_q;

    fault_expect_t fault_expect_q[$];
    fault_expect_t head;

    int  errors = 0;
    int  ticks_sent;
    int  results_checked = 0;
    int  code_hits[5] = '{default: 0};
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  rx_stall_left = 0;
    int  rx_hold_left = 0;
    int  rx_hold_seen = 0;
    int  rx_hold_req;
    int  rx_hold_seq;

    thermal_safety_monitor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .temp_quarter  (temp_quarter),
        .sensor_ok     (sensor_ok),
        .duty_permille (duty_permille),
        .fresh         (fresh),
        .delta_seconds (delta_seconds),
        .fault_valid   (fault_valid),
        .fault_stall   (fault_stall),
        .fault_code    (fault_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Gap length: mostly short, sometimes medium, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Saturating add of seconds into a counter.
    function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] acc,
                                                    logic [DELTA_BITS-1:0] d);
        logic [CNT_W:0] s;
        s = {1'b0, acc} + d;
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // Computes the fault code of one tick and advances the shadow state.
    function automatic fault_code_t predict_fault(tick_t t);
        int          rise;
        fault_code_t code;
        if (!t.ok)
            return FAULT_SENSOR;
        if ($signed(t.temp) >= ceil_q)
            return FAULT_OVERTEMP;
        // The stall check sees the sum before a fresh reading clears it.
        since_fresh_q = sat_count(since_fresh_q, t.delta);
        if (since_fresh_q >= stall_len_q)
            return FAULT_STALL;
        if (t.fresh)
            since_fresh_q = '0;
        code = FAULT_OK;
        if (t.duty > HEAT_THRESHOLD)
        begin
            if (win_elapsed_q == '0)
            begin
                win_base_q    = t.temp;
                win_elapsed_q = sat_count(win_elapsed_q, t.delta);
            end
            else
            begin
                win_elapsed_q = sat_count(win_elapsed_q, t.delta);
                if (win_elapsed_q >= window_len_q)
                begin
                    rise = int'($signed(t.temp)) - int'(win_base_q);
                    win_base_q    = t.temp;
                    win_elapsed_q = '0;
                    if (rise < int'(rise_min_q))
                        code = FAULT_RUNAWAY;
                end
            end
        end
        else
        begin
            win_base_q    = t.temp;
            win_elapsed_q = '0;
        end
        return code;
    endfunction

    function automatic tick_t mk_tick(int temp, int ok, int duty, int fr, int delta);
        tick_t t;
        t.temp  = TEMP_W'(temp);
        t.ok    = 1'(ok);
        t.duty  = DUTY_BITS'(duty);
        t.fresh = 1'(fr);
        t.delta = DELTA_BITS'(delta);
        return t;
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.temp  = TEMP_W'($urandom());
        t.ok    = ($urandom_range(0, 3) != 0);
        t.duty  = DUTY_BITS'($urandom());
        t.fresh = 1'($urandom_range(0, 1));
        t.delta = DELTA_BITS'($urandom());
        return t;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 100)
            $display("tb_top: mismatch: %s", msg);
    endtask

    task automatic drive_payload(tick_t t);
        temp_quarter  <= t.temp;
        sensor_ok     <= t.ok;
        duty_permille <= t.duty;
        fresh         <= t.fresh;
        delta_seconds <= t.delta;
    endtask

    // Offers one tick transaction and records its expected fault code once taken.
    task automatic send_tick(tick_t t);
        int            gap;
        fault_expect_t item;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
            gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            drive_payload(rand_tick());
            repeat (gap) @(negedge clk);
        end
        tick_valid <= 1'b1;
        drive_payload(t);
        do
            @(posedge clk);
        while (tick_stall);
        ticks_sent++;
        item.code    = predict_fault(t);
        item.tick_no = ticks_sent;
        fault_expect_q.push_back(item);
    endtask

    // Stops offering ticks and waits until every fault code has come back.
    task automatic wait_drained();
        @(negedge clk);
        tick_valid <= 1'b0;
        while (fault_expect_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One register write transaction; upper data bits are sometimes junk.
    task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
        logic [31:0] data;
        logic [31:0] keep;
        case (idx)
            REG_CEILING:  keep = (32'd1 << TEMP_W) - 1;
            REG_MIN_RISE: keep = (32'd1 << MIN_RISE_BITS) - 1;
            default:      keep = (32'd1 << SECONDS_BITS) - 1;
        endcase
        data = val & keep;
        if ($urandom_range(0, 3) == 0)
            data = data | ($urandom() & ~keep);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_CEILING:  ceil_q       = data[TEMP_W-1:0];
            REG_MIN_RISE: rise_min_q   = data[MIN_RISE_BITS-1:0];
            REG_WINDOW:   window_len_q = data[SECONDS_BITS-1:0];
            REG_STALL:    stall_len_q  = data[SECONDS_BITS-1:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A run of ticks: heating ramps with small steps, broken ramps, or pure noise.
    task automatic run_episode(episode_kind_t kind, int n);
        tick_t t;
        int    temp_i;
        int    slope;
        int    ceil_i;
        int    dmax;
        ceil_i = int'(ceil_q);
        temp_i = ceil_i - 20 - int'($urandom_range(0, 2000));
        if (temp_i < TEMP_MIN)
            temp_i = TEMP_MIN;
        slope = int'($urandom_range(0, 8)) - 2;
        for (int i = 0; i < n; i++)
        begin
            if (kind == EP_NOISE)
                t = rand_tick();
            else
            begin
                // Keep steps below the stall timeout so ramps reach the runaway check.
                dmax = (stall_len_q > 1) ? ((stall_len_q > 9) ? 8 : int'(stall_len_q) - 1) : 0;
                t.ok = ($urandom_range(0, 29) != 0);
                if ($urandom_range(0, 15) == 0)
                    t.duty = DUTY_BITS'($urandom_range(0, 500));
                else
                    t.duty = DUTY_BITS'($urandom_range(501, 1023));
                if (kind == EP_BROKEN && $urandom_range(0, 2) == 0)
                begin
                    t.fresh = 1'($urandom_range(0, 1));
                    t.delta = DELTA_BITS'($urandom());
                end
                else
                begin
                    t.fresh = ($urandom_range(0, 9) != 0);
                    t.delta = DELTA_BITS'($urandom_range(0, dmax));
                end
                temp_i = temp_i + slope * int'(t.delta) + int'($urandom_range(0, 2)) - 1;
                if (temp_i >= ceil_i)
                    temp_i = ceil_i - 1 - int'($urandom_range(0, 40));
                if (temp_i < TEMP_MIN)
                    temp_i = TEMP_MIN;
                t.temp = TEMP_W'(temp_i);
                if ($urandom_range(0, 39) == 0)
                    t.temp = TEMP_W'(ceil_i + int'($urandom_range(0, TEMP_MAX - ceil_i)));
            end
            send_tick(t);
        end
    endtask

    // Picks a new register setting between episodes and frees a stuck stall counter.
    task automatic randomize_config();
        int r;
        int v;
        wait_drained();
        if ($urandom_range(0, 9) < 6)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                v = TEMP_MIN;
            else if (r == 1)
                v = TEMP_MAX;
            else if (r == 2)
                v = $urandom();
            else
                v = int'($urandom_range(0, 5000)) - 2000;
            cfg_write(REG_CEILING, v);
        end
        if ($urandom_range(0, 9) < 6)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                v = 0;
            else if (r == 1)
                v = 4095;
            else if (r == 2)
                v = $urandom_range(0, 4095);
            else
                v = $urandom_range(0, 40);
            cfg_write(REG_MIN_RISE, v);
        end
        if ($urandom_range(0, 9) < 6)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                v = 0;
            else if (r == 1)
                v = 1;
            else if (r == 2)
                v = 65535;
            else if (r == 3)
                v = $urandom_range(0, 65535);
            else
                v = $urandom_range(2, 40);
            cfg_write(REG_WINDOW, v);
        end
        if ($urandom_range(0, 9) < 6 || since_fresh_q >= stall_len_q)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                v = 0;
            else if (r == 1)
                v = 1;
            else if (r == 2)
                v = 65535;
            else if (r == 3)
                v = $urandom_range(0, 65535);
            else
                v = $urandom_range(5, 40);
            // A tripped stall holds its sum; lift the timeout above it to recover.
            if (r >= 2 && v <= int'(since_fresh_q) + 8)
            begin
                v = int'(since_fresh_q) + int'($urandom_range(9, 300));
                if (v > 65535)
                    v = 65535;
            end
            cfg_write(REG_STALL, v);
        end
    endtask

    // Priority order, boundaries and window behavior under the reset settings.
    task automatic test_directed_cases();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        send_tick(mk_tick(TEMP_MAX, 0, 1023, 1, 255));
        send_tick(mk_tick(TEMP_MIN, 1, 0, 0, 0));
        send_tick(mk_tick(CEILING_RESET, 1, 0, 1, 0));
        send_tick(mk_tick(CEILING_RESET - 1, 1, 500, 1, 0));
        // Heating with zero delta leaves the window unopened.
        send_tick(mk_tick(200, 1, 501, 1, 0));
        send_tick(mk_tick(204, 1, 1023, 1, 2));
        send_tick(mk_tick(206, 1, 700, 1, 4));
        send_tick(mk_tick(207, 1, 700, 1, 4));
        send_tick(mk_tick(208, 1, 700, 1, 4));
        send_tick(mk_tick(209, 1, 700, 1, 4));
        // Rise one short of the minimum at the window end.
        send_tick(mk_tick(211, 1, 800, 1, 4));
        send_tick(mk_tick(211, 1, 900, 1, 4));
        send_tick(mk_tick(213, 1, 900, 1, 4));
        send_tick(mk_tick(215, 1, 900, 1, 4));
        send_tick(mk_tick(217, 1, 900, 1, 4));
        // Rise exactly at the minimum passes.
        send_tick(mk_tick(219, 1, 900, 1, 4));
        send_tick(mk_tick(150, 1, 500, 1, 1));
        // A fresh reading does not save the tick that reaches the timeout.
        send_tick(mk_tick(300, 1, 1000, 0, 3));
        send_tick(mk_tick(300, 1, 1000, 1, 2));
        send_tick(mk_tick(0, 0, 1000, 1, 0));
        send_tick(mk_tick(TEMP_MAX, 1, 1000, 1, 0));
        send_tick(mk_tick(0, 1, 0, 1, 0));
    endtask

    // Each register at its extremes and a few ordinary values, with a short ramp each.
    task automatic test_register_extremes();
        cfg_reg_t ext_reg [14] = '{REG_STALL, REG_CEILING, REG_CEILING, REG_CEILING,
                                  REG_MIN_RISE, REG_MIN_RISE, REG_WINDOW, REG_WINDOW,
                                  REG_WINDOW, REG_WINDOW, REG_MIN_RISE, REG_STALL,
                                  REG_STALL, REG_STALL};
        int       ext_val [14] = '{65535, TEMP_MAX, TEMP_MIN, 1000, 0, 4095, 0, 1,
                                  65535, 12, 10, 0, 1, 30};
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int i = 0; i < 14; i++)
        begin
            wait_drained();
            cfg_write(ext_reg[i], ext_val[i]);
            run_episode(EP_WELL, 15);
        end
    endtask

    // The receiver holds off for a long stretch while ticks keep coming.
    task automatic test_backpressure();
        wait_drained();
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_req = 150;
        rx_hold_seq++;
        run_episode(EP_WELL, 40);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int            start;
        int            r;
        episode_kind_t kind;
        start = ticks_sent;
        while (ticks_sent - start < 860)
        begin
            r = $urandom_range(0, 9);
            kind = (r < 6) ? EP_WELL : ((r < 8) ? EP_BROKEN : EP_NOISE);
            randomize_config();
            tx_idle_en = ($urandom_range(0, 9) < 7);
            rx_idle_en = ($urandom_range(0, 9) < 7);
            run_episode(kind, $urandom_range(8, 40));
        end
    endtask

    // Long heating run that drives the window counter to its top value.
    task automatic test_window_saturation();
        int temp_i;
        wait_drained();
        cfg_write(REG_STALL, 65535);
        cfg_write(REG_WINDOW, 65535);
        cfg_write(REG_CEILING, TEMP_MAX);
        cfg_write(REG_MIN_RISE, $urandom_range(0, 800));
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        temp_i = -4000;
        for (int i = 0; i < 300; i++)
        begin
            send_tick(mk_tick(temp_i, 1, 1000, 1, $urandom_range(240, 255)));
            temp_i = temp_i + int'($urandom_range(0, 3));
        end
    endtask

    // No fresh readings until the stall counter saturates; runs last since it never recovers.
    task automatic test_stall_saturation();
        for (int i = 0; i < 300; i++)
            send_tick(mk_tick($urandom_range(0, TEMP_MAX - 1), 1, $urandom_range(0, 1023),
                              0, $urandom_range(240, 255)));
    endtask

    // Receiver: random stall gaps, plus a long hold when a test asks for one.
    always @(negedge clk)
    begin
        if (rx_hold_seq != rx_hold_seen)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_seen = rx_hold_seq;
        end
        if (rx_hold_left > 0)
        begin
            fault_stall <= 1'b1;
            rx_hold_left--;
        end
        else if (rx_stall_left > 0)
        begin
            fault_stall <= 1'b1;
            rx_stall_left--;
        end
        else
        begin
            fault_stall <= 1'b0;
            if (rx_idle_en && $urandom_range(0, 4) == 0)
                rx_stall_left = pick_gap();
        end
    end

    // Checks each fault transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && fault_valid && !fault_stall)
        begin
            if (fault_expect_q.size() == 0)
                report_mismatch($sformatf("fault code %0d with no tick outstanding",
                                          fault_code));
            else
            begin
                head = fault_expect_q.pop_front();
                results_checked++;
                if (fault_code !== head.code)
                    report_mismatch($sformatf("tick %0d: fault code %0d, expected %0d",
                                              head.tick_no, fault_code, head.code));
                else
                    code_hits[int'(head.code)]++;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        tick_valid    = 1'b0;
        temp_quarter  = '0;
        sensor_ok     = 1'b0;
        duty_permille = '0;
        fresh         = 1'b0;
        delta_seconds = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_CEILING;
        cfg_data      = '0;
        ticks_sent    = 0;
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        rx_hold_req   = 0;
        rx_hold_seq   = 0;
        ceil_q        = TEMP_W'(CEILING_RESET);
        rise_min_q    = MIN_RISE_RESET;
        window_len_q  = WINDOW_RESET;
        stall_len_q   = STALL_RESET;
        since_fresh_q = '0;
        win_elapsed_q = '0;
        win_base_q    = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        test_window_saturation();
        test_stall_saturation();

        wait_drained();
        repeat (5) @(posedge clk);

        $display("tb_top: %0d ticks sent, %0d fault codes checked, %0d mismatches",
                 ticks_sent, results_checked, errors);
        $display("tb_top: codes matched ok=%0d sensor=%0d overtemp=%0d stall=%0d runaway=%0d",
                 code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4]);
        if (errors == 0 && fault_expect_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ thermal_safety_monitor.f @@
+incdir+hw/rtl
hw/rtl/tsm_pkg.sv
hw/rtl/tsm_eval.sv
hw/rtl/thermal_safety_monitor.sv
bench/tb_top.sv
